// ===== design/dsu_pkg.sv =====
// ----------------------------------------------------------------------------
// dsu_pkg
// Shared widths, codes and sequencer states of the quick-find union-find engine.
// ----------------------------------------------------------------------------
package dsu_pkg;

  localparam int VERTEX_W         = 5;
  localparam int LABEL_W          = 5;
  localparam int SIZE_W           = 6;
  localparam int COUNT_W          = 6;
  localparam int MERGE_W          = 5;
  localparam int VERTEX_LIMIT     = 32;
  localparam int MAX_VERTICES_DEF = 32;

  localparam logic [COUNT_W-1:0] VCOUNT_RESET = 6'd32;

  localparam logic OP_UNION = 1'b0;
  localparam logic OP_FIND  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ_LBL,
    ST_READ_CARD,
    ST_SCAN,
    ST_UPD_SRC,
    ST_UPD_DST,
    ST_FINISH
  } state_e;

endpackage

// ===== design/dsu_if.sv =====
// ----------------------------------------------------------------------------
// dsu_if
// Valid/ready channels for union-find requests and results.
// ----------------------------------------------------------------------------
interface dsu_req_if;
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic [dsu_pkg::VERTEX_W-1:0]  source_vertex;
  logic [dsu_pkg::VERTEX_W-1:0]  dest_vertex;

  modport source (output valid, operation, source_vertex, dest_vertex, input ready);
  modport sink   (input valid, operation, source_vertex, dest_vertex, output ready);
endinterface

interface dsu_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [dsu_pkg::LABEL_W-1:0]   set_index;
  logic                          merged;
  logic [dsu_pkg::SIZE_W-1:0]    set_size;
  logic [dsu_pkg::COUNT_W-1:0]   set_count;
  logic                          error;

  modport source (output valid, set_index, merged, set_size, set_count, error,
                  input ready);
  modport sink   (input valid, set_index, merged, set_size, set_count, error,
                  output ready);
endinterface

// ===== design/dsu_store.sv =====
// ----------------------------------------------------------------------------
// dsu_store
// Two-read, one-write RAM with per-entry valid bits; an invalid entry reads
// back with its valid flag low so the caller substitutes the reset value.
// ----------------------------------------------------------------------------
module dsu_store #(
  parameter int DEPTH = dsu_pkg::VERTEX_LIMIT,
  parameter int WIDTH = dsu_pkg::LABEL_W,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clear_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o,
  output logic             rvalid_a_o,
  output logic             rvalid_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid_q;
  logic [WIDTH-1:0] rdata_a_q, rdata_b_q;
  logic             rvalid_a_q, rvalid_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem[raddr_a_i];
    rdata_b_q <= mem[raddr_b_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rvalid_a_q <= 1'b0;
      rvalid_b_q <= 1'b0;
    end else begin
      if (clear_i) begin
        valid_q <= '0;
      end else if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      rvalid_a_q <= valid_q[raddr_a_i] & ~clear_i;
      rvalid_b_q <= valid_q[raddr_b_i] & ~clear_i;
    end
  end

  assign rdata_a_o  = rdata_a_q;
  assign rdata_b_o  = rdata_b_q;
  assign rvalid_a_o = rvalid_a_q;
  assign rvalid_b_o = rvalid_b_q;

endmodule

// ===== design/dsu_seq.sv =====
// ----------------------------------------------------------------------------
// dsu_seq
// Sequencer and shared compare/add datapath: label lookup, size lookup,
// one-vertex-per-cycle relabel sweep, size update and result register.
// ----------------------------------------------------------------------------
module dsu_seq #(
  parameter int MAX_VERTICES = dsu_pkg::MAX_VERTICES_DEF,
  localparam int NUM_SETS    = (MAX_VERTICES < dsu_pkg::VERTEX_LIMIT) ?
                               MAX_VERTICES : dsu_pkg::VERTEX_LIMIT,
  localparam int AW          = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [dsu_pkg::COUNT_W-1:0] cfg_wdata_i,
  dsu_req_if.sink                     req_i,
  dsu_rsp_if.source                   rsp_o,
  // label store
  output logic                        lbl_we_o,
  output logic [AW-1:0]               lbl_waddr_o,
  output logic [dsu_pkg::LABEL_W-1:0] lbl_wdata_o,
  output logic [AW-1:0]               lbl_raddr_a_o,
  output logic [AW-1:0]               lbl_raddr_b_o,
  input  logic [dsu_pkg::LABEL_W-1:0] lbl_rdata_a_i,
  input  logic [dsu_pkg::LABEL_W-1:0] lbl_rdata_b_i,
  input  logic                        lbl_rvalid_a_i,
  input  logic                        lbl_rvalid_b_i,
  // size store
  output logic                        card_we_o,
  output logic [AW-1:0]               card_waddr_o,
  output logic [dsu_pkg::SIZE_W-1:0]  card_wdata_o,
  output logic [AW-1:0]               card_raddr_a_o,
  output logic [AW-1:0]               card_raddr_b_o,
  input  logic [dsu_pkg::SIZE_W-1:0]  card_rdata_a_i,
  input  logic [dsu_pkg::SIZE_W-1:0]  card_rdata_b_i,
  input  logic                        card_rvalid_a_i,
  input  logic                        card_rvalid_b_i,
  output logic                        clear_o
);

  localparam int LW = dsu_pkg::LABEL_W;
  localparam int SW = dsu_pkg::SIZE_W;
  localparam int CW = dsu_pkg::COUNT_W;
  localparam int MW = dsu_pkg::MERGE_W;

  dsu_pkg::state_e state_q, state_d;

  logic [CW-1:0] vcount_q;
  logic [CW-1:0] n_active;
  logic          op_q;
  logic [LW-1:0] s_q, d_q;
  logic [SW-1:0] sum_q;
  logic [CW-1:0] scan_q;
  logic          pend_q;
  logic [AW-1:0] addr_a_q, addr_b_q;
  logic [MW-1:0] merge_q;

  logic [LW-1:0] res_set_q;
  logic          res_merged_q;
  logic [SW-1:0] res_size_q;
  logic          res_err_q;

  logic          out_valid_q;
  logic [LW-1:0] out_set_q;
  logic          out_merged_q;
  logic [SW-1:0] out_size_q;
  logic [CW-1:0] out_count_q;
  logic          out_err_q;

  logic          req_fire, bad_req, issue, out_load;
  logic [LW-1:0] lbl_eff_a, lbl_eff_b;
  logic [SW-1:0] card_eff_a, card_eff_b;
  logic [LW-1:0] cmp_a;
  logic          cmp_eq;
  logic [AW-1:0] lbl_ra;

  // clamp register value to 1..NUM_SETS
  always_comb begin
    n_active = vcount_q;
    if (vcount_q == '0) begin
      n_active = CW'(1);
    end else if (vcount_q > CW'(NUM_SETS)) begin
      n_active = CW'(NUM_SETS);
    end
  end

  assign req_fire = req_i.valid && req_i.ready;
  assign bad_req  = ({1'b0, req_i.source_vertex} >= n_active) ||
                    ((req_i.operation == dsu_pkg::OP_UNION) &&
                     ({1'b0, req_i.dest_vertex} >= n_active));

  // never-written entries read as their reset values
  assign lbl_eff_a  = lbl_rvalid_a_i  ? lbl_rdata_a_i  : LW'(addr_a_q);
  assign lbl_eff_b  = lbl_rvalid_b_i  ? lbl_rdata_b_i  : LW'(addr_b_q);
  assign card_eff_a = card_rvalid_a_i ? card_rdata_a_i : SW'(1);
  assign card_eff_b = card_rvalid_b_i ? card_rdata_b_i : SW'(1);

  // shared comparator: same-set check, then per-vertex match during the sweep
  assign cmp_a  = (state_q == dsu_pkg::ST_SCAN) ? lbl_eff_a : s_q;
  assign cmp_eq = (cmp_a == d_q);

  assign issue    = (scan_q < n_active);
  assign out_load = (state_q == dsu_pkg::ST_FINISH) && (!out_valid_q || rsp_o.ready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      dsu_pkg::ST_IDLE: begin
        if (req_fire) begin
          state_d = bad_req ? dsu_pkg::ST_FINISH : dsu_pkg::ST_READ_LBL;
        end
      end
      dsu_pkg::ST_READ_LBL:  state_d = dsu_pkg::ST_READ_CARD;
      dsu_pkg::ST_READ_CARD: begin
        if (op_q == dsu_pkg::OP_FIND || cmp_eq) begin
          state_d = dsu_pkg::ST_FINISH;
        end else begin
          state_d = dsu_pkg::ST_SCAN;
        end
      end
      dsu_pkg::ST_SCAN: begin
        if (!issue && !pend_q) begin
          state_d = dsu_pkg::ST_UPD_SRC;
        end
      end
      dsu_pkg::ST_UPD_SRC: state_d = dsu_pkg::ST_UPD_DST;
      dsu_pkg::ST_UPD_DST: state_d = dsu_pkg::ST_FINISH;
      dsu_pkg::ST_FINISH: begin
        if (out_load) begin
          state_d = dsu_pkg::ST_IDLE;
        end
      end
      default: state_d = dsu_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req_i.ready    = (state_q == dsu_pkg::ST_IDLE);
    clear_o        = cfg_we_i;
    lbl_ra         = req_i.source_vertex[AW-1:0];
    lbl_we_o       = 1'b0;
    lbl_waddr_o    = addr_a_q;
    lbl_wdata_o    = s_q;
    card_we_o      = 1'b0;
    card_waddr_o   = s_q[AW-1:0];
    card_wdata_o   = sum_q;
    card_raddr_a_o = lbl_eff_a[AW-1:0];
    card_raddr_b_o = lbl_eff_b[AW-1:0];
    case (state_q)
      dsu_pkg::ST_SCAN: begin
        lbl_ra   = scan_q[AW-1:0];
        lbl_we_o = pend_q && cmp_eq;
      end
      dsu_pkg::ST_UPD_SRC: begin
        card_we_o = 1'b1;
      end
      dsu_pkg::ST_UPD_DST: begin
        card_we_o    = 1'b1;
        card_waddr_o = d_q[AW-1:0];
        card_wdata_o = '0;
      end
      default: ;
    endcase
  end

  assign lbl_raddr_a_o = lbl_ra;
  assign lbl_raddr_b_o = req_i.dest_vertex[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dsu_pkg::ST_IDLE;
      vcount_q    <= dsu_pkg::VCOUNT_RESET;
      merge_q     <= '0;
      pend_q      <= 1'b0;
      scan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        vcount_q <= cfg_wdata_i;
        merge_q  <= '0;
      end else if (state_q == dsu_pkg::ST_UPD_DST) begin
        merge_q <= merge_q + MW'(1);
      end
      if (state_q == dsu_pkg::ST_SCAN) begin
        pend_q <= issue;
        if (issue) begin
          scan_q <= scan_q + CW'(1);
        end
      end else begin
        pend_q <= 1'b0;
        scan_q <= '0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    addr_a_q <= lbl_ra;
    addr_b_q <= lbl_raddr_b_o;
    case (state_q)
      dsu_pkg::ST_IDLE: begin
        op_q         <= req_i.operation;
        res_set_q    <= '0;
        res_merged_q <= 1'b0;
        res_size_q   <= '0;
        res_err_q    <= bad_req;
      end
      dsu_pkg::ST_READ_LBL: begin
        s_q <= lbl_eff_a;
        d_q <= lbl_eff_b;
      end
      dsu_pkg::ST_READ_CARD: begin
        res_set_q  <= s_q;
        res_size_q <= card_eff_a;
        sum_q      <= card_eff_a + card_eff_b;
      end
      dsu_pkg::ST_UPD_DST: begin
        res_merged_q <= 1'b1;
        res_size_q   <= sum_q;
      end
      default: ;
    endcase
    if (out_load) begin
      out_set_q    <= res_set_q;
      out_merged_q <= res_merged_q;
      out_size_q   <= res_size_q;
      out_count_q  <= n_active - CW'(merge_q);
      out_err_q    <= res_err_q;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.set_index = out_set_q;
  assign rsp_o.merged    = out_merged_q;
  assign rsp_o.set_size  = out_size_q;
  assign rsp_o.set_count = out_count_q;
  assign rsp_o.error     = out_err_q;

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> state_q != dsu_pkg::ST_IDLE)
    else $error("request accepted but sequencer stayed idle");

  a_merge_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == dsu_pkg::ST_IDLE |-> CW'(merge_q) < n_active)
    else $error("merge total reached active vertex count");

  a_relabel_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lbl_we_o |-> s_q != d_q)
    else $error("relabel within a single set");

  a_update_after_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == dsu_pkg::ST_UPD_SRC |-> $past(state_q) == dsu_pkg::ST_SCAN && !$past(pend_q))
    else $error("size update before sweep finished");

  a_find_no_merge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && op_q == dsu_pkg::OP_FIND |=> !rsp_o.merged)
    else $error("find reported a merge");

endmodule

// ===== design/disjoint_set_union_find.sv =====
// ----------------------------------------------------------------------------
// disjoint_set_union_find
// Quick-find union-find engine over up to 32 vertices.
// ----------------------------------------------------------------------------
// Requests enter on req_i (valid/ready), one at a time: operation 0 unions
// the sets of source_vertex and dest_vertex, 1 finds the set of
// source_vertex. Each request yields one result on rsp_o (valid/ready).
// cfg_we_i/cfg_wdata_i set the vertex count in use and restart every vertex
// as its own set; write only while no request is in flight.
// Steps per request, with n vertices in use:
//   union of two distinct sets: label read, size read, relabel sweep over
//     the n vertices reading one label per cycle on port A, size updates
//   find or union within one set: label read, size read; every request
//     ends in finish, an out-of-range index going there directly
// Reset, like a config write, clears the per-entry valid bits of both stores
// at once; no clearing pass. The output register holds a result while the
// receiver stalls; the next request is taken meanwhile and its result waits
// in the sequencer until the register frees.
// ----------------------------------------------------------------------------
module disjoint_set_union_find #(
  parameter int MAX_VERTICES = dsu_pkg::MAX_VERTICES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [dsu_pkg::COUNT_W-1:0] cfg_wdata_i,
  dsu_req_if.sink                     req_i,
  dsu_rsp_if.source                   rsp_o
);

  localparam int NUM_SETS = (MAX_VERTICES < dsu_pkg::VERTEX_LIMIT) ?
                            MAX_VERTICES : dsu_pkg::VERTEX_LIMIT;
  localparam int AW       = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;

  logic                        clear;
  logic                        lbl_we, card_we;
  logic [AW-1:0]               lbl_waddr, lbl_raddr_a, lbl_raddr_b;
  logic [AW-1:0]               card_waddr, card_raddr_a, card_raddr_b;
  logic [dsu_pkg::LABEL_W-1:0] lbl_wdata, lbl_rdata_a, lbl_rdata_b;
  logic [dsu_pkg::SIZE_W-1:0]  card_wdata, card_rdata_a, card_rdata_b;
  logic                        lbl_rvalid_a, lbl_rvalid_b;
  logic                        card_rvalid_a, card_rvalid_b;

  dsu_seq #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .req_i           (req_i),
    .rsp_o           (rsp_o),
    .lbl_we_o        (lbl_we),
    .lbl_waddr_o     (lbl_waddr),
    .lbl_wdata_o     (lbl_wdata),
    .lbl_raddr_a_o   (lbl_raddr_a),
    .lbl_raddr_b_o   (lbl_raddr_b),
    .lbl_rdata_a_i   (lbl_rdata_a),
    .lbl_rdata_b_i   (lbl_rdata_b),
    .lbl_rvalid_a_i  (lbl_rvalid_a),
    .lbl_rvalid_b_i  (lbl_rvalid_b),
    .card_we_o       (card_we),
    .card_waddr_o    (card_waddr),
    .card_wdata_o    (card_wdata),
    .card_raddr_a_o  (card_raddr_a),
    .card_raddr_b_o  (card_raddr_b),
    .card_rdata_a_i  (card_rdata_a),
    .card_rdata_b_i  (card_rdata_b),
    .card_rvalid_a_i (card_rvalid_a),
    .card_rvalid_b_i (card_rvalid_b),
    .clear_o         (clear)
  );

  dsu_store #(
    .DEPTH (NUM_SETS),
    .WIDTH (dsu_pkg::LABEL_W)
  ) u_label_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (clear),
    .we_i       (lbl_we),
    .waddr_i    (lbl_waddr),
    .wdata_i    (lbl_wdata),
    .raddr_a_i  (lbl_raddr_a),
    .raddr_b_i  (lbl_raddr_b),
    .rdata_a_o  (lbl_rdata_a),
    .rdata_b_o  (lbl_rdata_b),
    .rvalid_a_o (lbl_rvalid_a),
    .rvalid_b_o (lbl_rvalid_b)
  );

  dsu_store #(
    .DEPTH (NUM_SETS),
    .WIDTH (dsu_pkg::SIZE_W)
  ) u_size_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (clear),
    .we_i       (card_we),
    .waddr_i    (card_waddr),
    .wdata_i    (card_wdata),
    .raddr_a_i  (card_raddr_a),
    .raddr_b_i  (card_raddr_b),
    .rdata_a_o  (card_rdata_a),
    .rdata_b_o  (card_rdata_b),
    .rvalid_a_o (card_rvalid_a),
    .rvalid_b_o (card_rvalid_b)
  );

endmodule
